// ===== rtl/failed_login_lockout_table_defines.svh =====
// Assertion macros used by the lockout table walker (flt_ctrl).
`ifndef FAILED_LOGIN_LOCKOUT_TABLE_DEFINES_SVH
`define FAILED_LOGIN_LOCKOUT_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/flt_pkg.sv =====
// Types, constants and name helpers for the failed-login lockout table.
package flt_pkg;

    localparam int ENTRIES    = 256;
    localparam int ENTRY_AW   = $clog2(ENTRIES);
    localparam int NAME_W     = 256;
    localparam int NAME_BYTES = NAME_W / 8;
    localparam int WINDOW_W   = 17;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(300);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_WINDOW = 1'b1;

    // opcodes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // key modes
    localparam logic MODE_IP   = 1'b0;
    localparam logic MODE_NAME = 1'b1;

    typedef struct packed {
        logic [15:0]       count;
        logic [31:0]       last_time;
        logic [NAME_W-1:0] name;
        logic [31:0]       ip;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              op;
        logic              mode;
        logic [31:0]       ip;
        logic [31:0]       now;
        logic [31:0]       limit;
        logic [NAME_W-1:0] name_clean;
        logic [NAME_W-1:0] name_fold;
    } t_item;

    typedef struct packed {
        logic [15:0] attempt_count;
        logic        cleared;
    } t_result;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_RESP
    } t_state;

    // Zero every byte after the first zero byte.
    function automatic logic [NAME_W-1:0] name_clean(input logic [NAME_W-1:0] n);
        logic [NAME_W-1:0] c;
        logic              alive;
        c     = '0;
        alive = 1'b1;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (n[8*k +: 8] == 8'h00) begin
                alive = 1'b0;
            end
            if (alive) begin
                c[8*k +: 8] = n[8*k +: 8];
            end
        end
        return c;
    endfunction

    // Fold A-Z to a-z byte by byte.
    function automatic logic [NAME_W-1:0] name_fold(input logic [NAME_W-1:0] n);
        logic [NAME_W-1:0] f;
        logic [7:0]        b;
        f = n;
        for (int k = 0; k < NAME_BYTES; k++) begin
            b = n[8*k +: 8];
            if (b >= 8'h41 && b <= 8'h5A) begin
                f[8*k +: 8] = b + 8'h20;
            end
        end
        return f;
    endfunction

endpackage

// ===== rtl/flt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module flt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/flt_ctrl.sv =====
// Table walker: clearing pass, read-modify-write scan, insert and result.
`include "failed_login_lockout_table_defines.svh"

module flt_ctrl
    import flt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    input  logic    i_res_take,
    output logic    o_idle,
    output logic    o_res_valid,
    output t_result o_res
);

    t_state                r_state, n_state;
    t_item                 r_item;
    logic [ENTRY_AW:0]     r_rd_idx, n_rd_idx;
    logic                  r_dv, n_dv;
    logic [ENTRY_AW-1:0]   r_dv_idx;
    logic                  r_free_vld, n_free_vld;
    logic [ENTRY_AW-1:0]   r_free_idx, n_free_idx;
    t_result               r_res, n_res;

    logic                  rd_en;
    logic                  wr_en;
    logic [ENTRY_AW-1:0]   wr_addr;
    t_entry                wr_data;
    logic [ENTRY_W-1:0]    rdata;
    t_entry                ent;
    logic                  expired;
    logic                  match;
    logic                  last;
    logic                  hit;
    logic [15:0]           count_inc;

    flt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[ENTRY_AW-1:0]),
        .o_rdata (rdata)
    );

    assign ent       = t_entry'(rdata);
    assign expired   = ent.last_time < r_item.limit;
    assign match     = (r_item.mode == MODE_NAME) ? (name_fold(ent.name) == r_item.name_fold)
                                                  : (ent.ip == r_item.ip);
    assign last      = r_dv_idx == ENTRY_AW'(ENTRIES - 1);
    assign hit       = (r_state == ST_SCAN) && r_dv && !expired && match;
    assign count_inc = (ent.count == 16'hFFFF) ? ent.count : ent.count + 16'd1;
    assign rd_en     = (r_state == ST_SCAN) && (r_rd_idx < (ENTRY_AW + 1)'(ENTRIES));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_rd_idx == (ENTRY_AW + 1)'(ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_dv) begin
                    priority if (r_item.op == OP_RECORD && hit) begin
                        n_state = ST_RESP;
                    end else if (last && r_item.op == OP_RECORD
                                 && (r_free_vld || expired)) begin
                        n_state = ST_INSERT;
                    end else if (last) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_INSERT: n_state = ST_RESP;
            ST_RESP: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_rd_idx   = r_rd_idx;
        n_dv       = 1'b0;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_res      = r_res;
        wr_en      = 1'b0;
        wr_addr    = r_dv_idx;
        wr_data    = '0;
        unique case (r_state)
            ST_INIT: begin
                wr_en    = 1'b1;
                wr_addr  = r_rd_idx[ENTRY_AW-1:0];
                n_rd_idx = r_rd_idx + 1'b1;
            end
            ST_IDLE: begin
                n_rd_idx   = '0;
                n_free_vld = 1'b0;
                n_res      = '0;
            end
            ST_SCAN: begin
                n_dv = rd_en;
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_dv) begin
                    if (expired) begin
                        // expired: drop ip, time and count; a clear keeps the name
                        wr_en = 1'b1;
                        if (r_item.op == OP_CLEAR) begin
                            wr_data.name = ent.name;
                        end
                        if (!r_free_vld) begin
                            n_free_vld = 1'b1;
                            n_free_idx = r_dv_idx;
                        end
                    end else if (match) begin
                        wr_en = 1'b1;
                        if (r_item.op == OP_RECORD) begin
                            wr_data.count     = count_inc;
                            wr_data.last_time = r_item.now;
                            wr_data.name      = ent.name;
                            wr_data.ip        = ent.ip;
                            n_res.attempt_count = count_inc;
                        end else begin
                            n_res.cleared = 1'b1;
                        end
                    end
                end
            end
            ST_INSERT: begin
                wr_en             = 1'b1;
                wr_addr           = r_free_idx;
                wr_data.count     = 16'd1;
                wr_data.last_time = r_item.now;
                wr_data.name      = r_item.name_clean;
                wr_data.ip        = r_item.ip;
                n_res.attempt_count = 16'd1;
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_rd_idx   <= '0;
            r_dv       <= 1'b0;
            r_free_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_idx   <= n_rd_idx;
            r_dv       <= n_dv;
            r_free_vld <= n_free_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_idx   <= r_rd_idx[ENTRY_AW-1:0];
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
        if (i_start) begin
            r_item <= i_item;
        end
    end

    assign o_idle      = r_state == ST_IDLE;
    assign o_res_valid = r_state == ST_RESP;
    assign o_res       = r_res;

    `FLT_ASSERT_NOW(a_no_rw_overlap, i_clk, i_rst_n, wr_en && rd_en,
        wr_addr != r_rd_idx[ENTRY_AW-1:0], "read and write hit the same entry")
    `FLT_ASSERT_NOW(a_insert_has_slot, i_clk, i_rst_n, r_state == ST_INSERT,
        r_free_vld, "insert without a free slot")
    `FLT_ASSERT_NEXT(a_start_scans, i_clk, i_rst_n, i_start && r_state == ST_IDLE,
        r_state == ST_SCAN && !r_dv && r_rd_idx == '0, "start did not open a walk")
    `FLT_ASSERT_NOW(a_result_kind, i_clk, i_rst_n, r_state == ST_RESP,
        (r_item.op == OP_RECORD && !r_res.cleared)
        || (r_item.op == OP_CLEAR && r_res.attempt_count == '0),
        "result fields disagree with opcode")

endmodule

// ===== rtl/failed_login_lockout_table.sv =====
// Top level of the failed-login lockout table: ports, registers and result stage.
//
// Failed-login lockout table. Keeps ENTRIES failure counters, keyed by client
// IPv4 address (lock_mode 0) or by a case-insensitive user name of up to 32
// bytes (lock_mode 1). A record transaction (tuser 0) walks the table,
// clearing expired entries until it meets the first live match, bumps that
// count (saturating) and returns it; with no match the first expired slot
// takes the key with count 1, and a full table returns 0. A clear transaction
// (tuser 1) walks every entry and reports whether a live match was wiped.
// All entries sit in one RAM with a registered read; the walk reads one
// entry per cycle through that single read port and writes back expired
// and matching entries. One item is in the walker at a time; the next one
// is taken as soon as the result has moved to the output register. After
// reset a clearing pass zeroes every entry of the RAM, with s_axis_tready
// low; configuration writes are taken throughout, and must only be issued
// while the block is idle.
module failed_login_lockout_table
    import flt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WINDOW_W-1:0]  i_cfg_wdata,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // client_ip, now_seconds, name_part_a, name_part_b, name_part_c, name_part_d
    input  logic [319:0]         s_axis_tdata,
    // opcode
    input  logic                 s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // attempt_count, cleared, zero pad
    output logic [23:0]          m_axis_tdata
);

    logic                r_lock_mode;
    logic [WINDOW_W-1:0] r_lock_window;
    logic                r_m_tvalid, n_m_tvalid;
    logic [23:0]         r_m_tdata;

    logic                start;
    logic                ctrl_idle;
    logic                res_valid;
    logic                res_take;
    t_result             res;
    t_item               item;
    logic [NAME_W-1:0]   name_raw;
    logic [31:0]         now;

    // hold the configuration registers; unknown indexes cannot occur
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_mode   <= MODE_IP;
            r_lock_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOCK_MODE:   r_lock_mode   <= i_cfg_wdata[0];
                CFG_LOCK_WINDOW: r_lock_window <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // build the walker's view of one transaction; the name is trimmed after
    // its terminator, and a folded copy drives the case-insensitive compare
    assign name_raw        = s_axis_tdata[319:64];
    assign now             = s_axis_tdata[63:32];
    assign item.op         = s_axis_tuser;
    assign item.mode       = r_lock_mode;
    assign item.ip         = s_axis_tdata[31:0];
    assign item.now        = now;
    assign item.limit      = now - {{(32 - WINDOW_W){1'b0}}, r_lock_window};
    assign item.name_clean = name_clean(name_raw);
    assign item.name_fold  = name_fold(item.name_clean);

    assign s_axis_tready = ctrl_idle;
    assign start         = s_axis_tvalid && ctrl_idle;

    // advance a finished result into the output register once it is free
    assign res_take = res_valid && (!r_m_tvalid || m_axis_tready);

    flt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (item),
        .i_res_take  (res_take),
        .o_idle      (ctrl_idle),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_m_tvalid = r_m_tvalid;
        if (res_take) begin
            n_m_tvalid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else begin
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_m_tdata <= {7'd0, res.cleared, res.attempt_count};
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

endmodule
